// ===== sv/scds_pkg.sv =====
// ----------------------------------------------------------------------------
// scds_pkg
// shared constants and the per-request record of the clock divider search
// ----------------------------------------------------------------------------
package scds_pkg;

    localparam int PRESCALE_MAX_DEF = 16;
    localparam int COUNT_MAX_DEF    = 64;

    // width that holds any counter length or prescaler value in range
    localparam int NW = 9;

    localparam logic [29:0] SRC_RESET  = 30'd40000000;
    localparam logic [7:0]  DUTY_RESET = 8'd128;

    // reciprocal scaling for the constant dividers
    localparam int RECIP_SHIFT = 32;

    // x / 255 for x below 65535 equals ((x + 1) * 257) >> 16
    localparam int DUTY_RECIP = 257;
    localparam int DUTY_SHIFT = 16;

    typedef enum logic {
        REG_SOURCE_FREQ = 1'b0,
        REG_DUTY_LEVEL  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [29:0]   tgt;
        logic [29:0]   src;
        logic [7:0]    duty;
        logic          pass;
        logic          fast;
        logic [29:0]   min_gap;
        logic [NW-1:0] best_n;
        logic [NW-1:0] sel_pre;
    } item_t;

endpackage

// ===== sv/spi_clock_divider_search_unit.sv =====
// ----------------------------------------------------------------------------
// spi_clock_divider_search_unit
// picks spi clock prescaler and counter fields for a target frequency
// ----------------------------------------------------------------------------
//
// channel  | direction | contents
// s_       | in        | tdata: target_freq[29:0]
// m_       | out       | tdata: prescale_minus_one, count_minus_one, low_count,
//          |           |        high_count; tuser: equal_sysclk
// apb      | config    | 0x0 source_freq, 0x4 duty_level
//
// one request per cycle while no result waits unaccepted; the pipe is mostly the chain
// of candidate evaluators, one per counter length, seven stages each
// reset clears the valid bits and loads the register defaults, no sweep
// the whole pipe advances together and holds while a result waits unaccepted
// configuration is expected only while no request is in flight
//
module spi_clock_divider_search_unit #(
    parameter int PRESCALE_MAX = scds_pkg::PRESCALE_MAX_DEF,
    parameter int COUNT_MAX    = scds_pkg::COUNT_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [29:0] target_freq
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [3:0] prescale_minus_one, [9:4] count_minus_one,
                                     // [15:10] low_count, [21:16] high_count
    output logic        m_tuser,     // [0] equal_sysclk
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [29:0] source_freq_reg;
    logic [7:0]  duty_level_reg;
    logic        cfg_wr;
    logic        en;

    logic            chain_valid [COUNT_MAX];
    scds_pkg::item_t chain_item  [COUNT_MAX];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register file, word aligned
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_freq_reg <= scds_pkg::SRC_RESET;
            duty_level_reg  <= scds_pkg::DUTY_RESET;
        end else if (cfg_wr) begin
            case (scds_pkg::reg_idx_t'(paddr[2]))
                scds_pkg::REG_SOURCE_FREQ: source_freq_reg <= pwdata[29:0];
                scds_pkg::REG_DUTY_LEVEL:  duty_level_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (scds_pkg::reg_idx_t'(paddr[2]))
            scds_pkg::REG_SOURCE_FREQ: prdata = {2'b00, source_freq_reg};
            scds_pkg::REG_DUTY_LEVEL:  prdata = {24'd0, duty_level_reg};
            default:                   prdata = '0;
        endcase
    end

    // global advance: stall only while the result register holds an untaken result
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    scds_entry #(
        .PRESCALE_MAX(PRESCALE_MAX),
        .COUNT_MAX   (COUNT_MAX)
    ) u_entry (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_tgt   (s_tdata[29:0]),
        .src      (source_freq_reg),
        .duty     (duty_level_reg),
        .out_valid(chain_valid[0]),
        .out_item (chain_item[0])
    );

    // candidates from the longest counter down, so earlier wins ties
    for (genvar i = 0; i < COUNT_MAX - 1; i++) begin : g_cand
        scds_cand #(
            .PRESCALE_MAX(PRESCALE_MAX),
            .N_VAL       (COUNT_MAX - i)
        ) u_cand (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (chain_valid[i]),
            .in_item  (chain_item[i]),
            .out_valid(chain_valid[i+1]),
            .out_item (chain_item[i+1])
        );
    end

    scds_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (chain_valid[COUNT_MAX-1]),
        .in_item  (chain_item[COUNT_MAX-1]),
        .out_valid(m_tvalid),
        .out_tdata(m_tdata),
        .out_tuser(m_tuser)
    );

endmodule

// ===== sv/scds_entry.sv =====
// ----------------------------------------------------------------------------
// scds_entry
// request entry stage: zero fixup, pass-through and too-fast checks
// ----------------------------------------------------------------------------
module scds_entry #(
    parameter int PRESCALE_MAX = scds_pkg::PRESCALE_MAX_DEF,
    parameter int COUNT_MAX    = scds_pkg::COUNT_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [29:0]        in_tgt,
    input  logic [29:0]        src,
    input  logic [7:0]         duty,
    output logic               out_valid,
    output scds_pkg::item_t    out_item
);

    localparam int PN = PRESCALE_MAX * COUNT_MAX;

    logic            valid_reg;
    scds_pkg::item_t item_reg;
    scds_pkg::item_t item_next;
    logic [29:0]     tgt1;
    logic [30:0]     tgt_p1;
    logic [47:0]     lim;

    always_comb begin
        tgt1   = (in_tgt == 30'd0) ? 30'd1 : in_tgt;
        tgt_p1 = 31'(tgt1) + 31'd1;
        // src / (P*N) > tgt  <=>  src >= (tgt + 1) * P * N
        lim    = 48'(tgt_p1) * 48'(PN);
        item_next.tgt      = tgt1;
        item_next.src      = src;
        item_next.duty     = duty;
        item_next.pass     = (tgt1 >= src);
        item_next.fast     = (48'(src) >= lim);
        item_next.min_gap  = tgt1;
        item_next.best_n   = scds_pkg::NW'(COUNT_MAX);
        item_next.sel_pre  = scds_pkg::NW'(PRESCALE_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== sv/scds_cand.sv =====
// ----------------------------------------------------------------------------
// scds_cand
// seven-stage evaluation of one counter length against the running best
// ----------------------------------------------------------------------------
module scds_cand #(
    parameter int PRESCALE_MAX = scds_pkg::PRESCALE_MAX_DEF,
    parameter int N_VAL        = scds_pkg::COUNT_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  scds_pkg::item_t    in_item,
    output logic               out_valid,
    output scds_pkg::item_t    out_item
);

    localparam int NW  = scds_pkg::NW;
    localparam int RS  = scds_pkg::RECIP_SHIFT;
    localparam logic [31:0] RN = 32'((64'd1 << RS) / N_VAL);
    localparam int PIW = (PRESCALE_MAX > 1) ? $clog2(PRESCALE_MAX) : 1;
    localparam int RD  = 2 ** PIW;

    logic [32:0] recip_tab [RD];

    for (genvar i = 0; i < RD; i++) begin : g_recip
        localparam logic [32:0] RV = (i < PRESCALE_MAX) ?
                                     33'((64'd1 << RS) / (i + 1)) : 33'd0;
        assign recip_tab[i] = RV;
    end

    logic [7:1]      vld_reg;
    scds_pkg::item_t it1_reg, it2_reg, it3_reg, it4_reg, it5_reg, it6_reg, it7_reg;
    scds_pkg::item_t it7_next;
    logic [29:0]     est1_reg, est1_next;
    logic [29:0]     per2_reg, per2_next;
    logic [29:0]     per3_reg;
    logic [NW-1:0]   q03_reg, q03_next;
    logic [29:0]     per4_reg;
    logic [NW-1:0]   pre4_reg, pre4_next;
    logic            ok4_reg, ok4_next;
    logic [29:0]     per5_reg;
    logic [NW-1:0]   pre5_reg;
    logic            ok5_reg;
    logic [29:0]     d5_reg, d5_next;
    logic [NW-1:0]   pre6_reg;
    logic            ok6_reg;
    logic [29:0]     d6_reg, d6_next;

    logic [63:0]     prod1;
    logic [38:0]     back2, rem2;
    logic [NW-1:0]   pre1;
    logic [39:0]     lim4;
    logic            bump4;
    logic [NW-1:0]   pm1;
    logic [PIW-1:0]  idx5;
    logic [62:0]     prod5;
    logic [38:0]     back6, rem6;
    logic [29:0]     err7;

    // stage 1: source / n estimate by reciprocal
    always_comb begin
        prod1     = 64'(in_item.src) * 64'(RN);
        est1_next = prod1[RS+29:RS];
    end

    // stage 2: one correction step gives the exact period
    always_comb begin
        back2     = 39'(est1_reg) * 39'(N_VAL);
        rem2      = 39'(it1_reg.src) - back2;
        per2_next = est1_reg + 30'(rem2 >= 39'(N_VAL));
    end

    // stage 3: period / target, saturated just above the prescaler range
    always_comb begin
        q03_next = '0;
        for (int k = 1; k <= PRESCALE_MAX + 1; k++) begin
            if (39'(per2_reg) >= 39'(it2_reg.tgt) * 39'(k)) begin
                q03_next = NW'(k);
            end
        end
    end

    // stage 4: bump the prescaler when the output still overshoots
    always_comb begin
        pre1      = (q03_reg == '0) ? NW'(1) : q03_reg;
        lim4      = 40'(31'(it3_reg.tgt) + 31'd1) * 40'(pre1);
        bump4     = (40'(per3_reg) >= lim4);
        pre4_next = pre1 + NW'(bump4);
        ok4_next  = (pre4_next <= NW'(PRESCALE_MAX));
    end

    // stage 5: output frequency estimate by reciprocal of the prescaler
    always_comb begin
        pm1     = pre4_reg - NW'(1);
        idx5    = ok4_reg ? pm1[PIW-1:0] : '0;
        prod5   = 63'(per4_reg) * 63'(recip_tab[idx5]);
        d5_next = prod5[RS+29:RS];
    end

    // stage 6: correction step
    always_comb begin
        back6   = 39'(d5_reg) * 39'(pre5_reg);
        rem6    = 39'(per5_reg) - back6;
        d6_next = d5_reg + 30'(rem6 >= 39'(pre5_reg));
    end

    // stage 7: strict compare keeps the larger n on a tie
    always_comb begin
        err7     = it6_reg.tgt - d6_reg;
        it7_next = it6_reg;
        if (!it6_reg.pass && !it6_reg.fast && ok6_reg && (err7 < it6_reg.min_gap)) begin
            it7_next.min_gap = err7;
            it7_next.best_n  = NW'(N_VAL);
            it7_next.sel_pre = pre6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it1_reg  <= in_item;
            est1_reg <= est1_next;
            it2_reg  <= it1_reg;
            per2_reg <= per2_next;
            it3_reg  <= it2_reg;
            per3_reg <= per2_reg;
            q03_reg  <= q03_next;
            it4_reg  <= it3_reg;
            per4_reg <= per3_reg;
            pre4_reg <= pre4_next;
            ok4_reg  <= ok4_next;
            it5_reg  <= it4_reg;
            per5_reg <= per4_reg;
            pre5_reg <= pre4_reg;
            ok5_reg  <= ok4_reg;
            d5_reg   <= d5_next;
            it6_reg  <= it5_reg;
            pre6_reg <= pre5_reg;
            ok6_reg  <= ok5_reg;
            d6_reg   <= d6_next;
            it7_reg  <= it7_next;
        end
    end

    assign out_valid = vld_reg[7];
    assign out_item  = it7_reg;

endmodule

// ===== sv/scds_out.sv =====
// ----------------------------------------------------------------------------
// scds_out
// duty mapping, field packing and the result register
// ----------------------------------------------------------------------------
module scds_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  scds_pkg::item_t    in_item,
    output logic               out_valid,
    output logic [23:0]        out_tdata,
    output logic               out_tuser
);

    localparam int DS = scds_pkg::DUTY_SHIFT;

    logic        valid_reg;
    logic [23:0] tdata_reg, tdata_next;
    logic        tuser_reg, tuser_next;
    logic [scds_pkg::NW-1:0] nm2, nm1, pm1;
    logic [16:0] x;
    logic [25:0] hq;

    always_comb begin
        nm1 = in_item.best_n - scds_pkg::NW'(1);
        nm2 = in_item.best_n - scds_pkg::NW'(2);
        pm1 = in_item.sel_pre - scds_pkg::NW'(1);
        x   = 17'(in_item.duty) * 17'(nm2);
        // divide by 255
        hq  = 26'(18'(x) + 18'd1) * 26'(scds_pkg::DUTY_RECIP);
        if (in_item.pass) begin
            tdata_next = '0;
            tuser_next = 1'b1;
        end else begin
            tdata_next = {2'b00, hq[DS+5:DS], nm1[5:0], nm1[5:0], pm1[3:0]};
            tuser_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tdata = tdata_reg;
    assign out_tuser = tuser_reg;

endmodule

// ===== sv/scds_checker.sv =====
// ----------------------------------------------------------------------------
// scds_checker
// port-level checks on the clock divider search unit
// ----------------------------------------------------------------------------
module scds_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // pass-through carries all-zero divider fields
    a_pass_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("pass-through with nonzero fields");

    // low count mirrors counter length
    a_low_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[9:4] == m_tdata[15:10])
        else $error("low count differs from counter length");

    // full result register blocks new requests
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result stalled");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind spi_clock_divider_search_unit scds_checker u_scds_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
